>>> rtl/todc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-of-day clock package
// Shared types, constants and codes for the time-of-day clock with
// periodic triggers.
// ----------------------------------------------------------------------------
package todc_pkg;

  // Tenth-second ticks that make up one second.
  localparam int TICKS_PER_SECOND = 10;
  localparam int TENTHS_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;

  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int VALUE_W  = 6;

  localparam logic [HOUR_W-1:0]   HOUR_LAST   = HOUR_W'(23);
  localparam logic [MINUTE_W-1:0] MINUTE_LAST = MINUTE_W'(59);
  localparam logic [SECOND_W-1:0] SECOND_LAST = SECOND_W'(59);

  // Configuration registers.
  localparam int SEC_PERIOD_W = 12;
  localparam int MIN_PERIOD_W = 11;
  localparam int CFG_DATA_W   = 12;
  localparam int CFG_IDX_W    = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SECOND_PERIOD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MINUTE_PERIOD = CFG_IDX_W'(1);

  localparam logic [SEC_PERIOD_W-1:0] SEC_PERIOD_RESET = SEC_PERIOD_W'(60);
  localparam logic [MIN_PERIOD_W-1:0] MIN_PERIOD_RESET = MIN_PERIOD_W'(1);

  // Width of the shared remainder unit: covers second-of-hour (up to 3599)
  // and the widest period register.
  localparam int DIV_W = 12;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_SET_HOUR   = 2'd1,
    OP_SET_MINUTE = 2'd2,
    OP_SET_SECOND = 2'd3
  } op_t;

  typedef struct packed {
    op_t                 operation;
    logic [VALUE_W-1:0]  value;
  } in_word_t;

  typedef struct packed {
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
    logic                second_fire;
    logic                minute_fire;
  } out_word_t;

  typedef struct packed {
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } time_t;

  typedef struct packed {
    logic               start;
    logic [DIV_W-1:0]   dividend;
    logic [DIV_W-1:0]   divisor;
  } rem_ctrl_t;

  typedef struct packed {
    logic busy;
    logic zero;
  } rem_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEC_START,
    S_SEC_WAIT,
    S_MIN_START,
    S_MIN_WAIT,
    S_DONE
  } state_t;

endpackage

>>> rtl/todc_rem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared remainder unit
// Restoring division, one quotient bit per cycle; reports whether the
// remainder is zero.
// ----------------------------------------------------------------------------
module todc_rem
  import todc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  rem_ctrl_t ctrl,
  output rem_stat_t stat
);

  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     dvd;
  logic [DIV_W-1:0]     dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [DIV_W:0]       trial;
  logic [DIV_W:0]       diff;
  logic [DIV_W-1:0]     rem_next;

  always_comb begin
    trial = {rem, dvd[DIV_W-1]};
    diff  = trial - {1'b0, dvs};
    // Remainder stays below the divisor, so it fits back in DIV_W bits.
    rem_next = diff[DIV_W] ? trial[DIV_W-1:0] : diff[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ctrl.start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(DIV_W);
      rem  <= '0;
      dvd  <= ctrl.dividend;
      dvs  <= ctrl.divisor;
    end else if (busy) begin
      rem  <= rem_next;
      dvd  <= {dvd[DIV_W-2:0], 1'b0};
      cnt  <= cnt - DIV_CNT_W'(1);
      busy <= (cnt != DIV_CNT_W'(1));
    end
  end

  assign stat.busy = busy;
  assign stat.zero = (rem == '0);

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    ctrl.start |=> busy) else $error("remainder unit did not start");

  a_last_step: assert property (@(posedge clk) disable iff (rst)
    (busy && !ctrl.start && cnt == DIV_CNT_W'(1)) |=> !busy)
    else $error("remainder unit ran past its last step");

endmodule

>>> rtl/todc_time.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-of-day counters
// Tenths, seconds, minutes and hours with tick carry and set operations.
// ----------------------------------------------------------------------------
module todc_time
  import todc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     update,
  input  in_word_t word,
  output time_t    now
);

  logic [TENTHS_W-1:0] tenths;
  logic [TENTHS_W-1:0] tenths_next;
  time_t               cur;
  time_t               cur_next;

  always_comb begin
    tenths_next = tenths;
    cur_next    = cur;
    case (word.operation)
      OP_TICK: begin
        if (tenths == TENTHS_W'(TICKS_PER_SECOND - 1)) begin
          tenths_next = '0;
          if (cur.second == SECOND_LAST) begin
            cur_next.second = '0;
            if (cur.minute == MINUTE_LAST) begin
              cur_next.minute = '0;
              cur_next.hour = (cur.hour == HOUR_LAST) ? '0 : cur.hour + HOUR_W'(1);
            end else begin
              cur_next.minute = cur.minute + MINUTE_W'(1);
            end
          end else begin
            cur_next.second = cur.second + SECOND_W'(1);
          end
        end else begin
          tenths_next = tenths + TENTHS_W'(1);
        end
      end
      OP_SET_HOUR: begin
        // Out-of-range values leave the time unchanged.
        if (word.value <= VALUE_W'(HOUR_LAST)) begin
          cur_next.hour = word.value[HOUR_W-1:0];
        end
      end
      OP_SET_MINUTE: begin
        if (word.value <= MINUTE_LAST) begin
          cur_next.minute = word.value;
        end
      end
      OP_SET_SECOND: begin
        if (word.value <= SECOND_LAST) begin
          cur_next.second = word.value;
        end
      end
      default: begin
        cur_next = cur;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tenths <= '0;
      cur    <= '0;
    end else if (update) begin
      tenths <= tenths_next;
      cur    <= cur_next;
    end
  end

  assign now = cur;

endmodule

>>> rtl/time_of_day_clock_periodic_trigger_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-of-day clock with periodic triggers
// Keeps hours, minutes, seconds and tenths, and raises one-shot triggers
// when the second of the hour or the minute of the day hits a multiple of
// a configured period.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall, in_data) carries one word per
// item: a tenth-second tick or a set of the hour, minute or second. The
// output channel (out_valid, out_stall, out_data) returns exactly one word
// per item with the time after that item and the two trigger flags.
// The configuration port (cfg_write, cfg_index, cfg_data) writes
// second_period (index 0) and minute_period (index 1); write them only
// while no item is in flight.
// The block takes no new item until the result of the last one is loaded
// into the output register. Each item runs the single shared remainder
// unit twice, once for the seconds trigger and once for minutes; the unit
// resolves one quotient bit per cycle (12 bits).
// Reset (rst, synchronous) clears the time to 00:00:00.0, clears both
// trigger flags, sets second_period to 60 and minute_period to 1, and
// empties the output register. While out_stall holds a finished word,
// the block still accepts and works on the next item, and then waits to
// load its result until the output register is free.
// ----------------------------------------------------------------------------
module time_of_day_clock_periodic_trigger_top
  import todc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t                  state;
  state_t                  state_next;
  logic [SEC_PERIOD_W-1:0] second_period;
  logic [MIN_PERIOD_W-1:0] minute_period;
  logic                    second_done;
  logic                    minute_done;
  logic                    sec_zero;
  logic                    min_zero;
  logic                    in_accept;
  logic                    load_out;
  time_t                   now;
  rem_ctrl_t               rem_ctrl;
  rem_stat_t               rem_stat;
  logic [DIV_W-1:0]        sec_of_hour;
  logic [DIV_W-1:0]        min_of_day;
  logic [DIV_W-1:0]        sec_divisor;
  logic [DIV_W-1:0]        min_divisor;

  assign in_accept = in_valid && !in_stall;

  // Time counters advance at the edge where the item is accepted.
  todc_time u_time (
    .clk    (clk),
    .rst    (rst),
    .update (in_accept),
    .word   (in_data),
    .now    (now)
  );

  todc_rem u_rem (
    .clk  (clk),
    .rst  (rst),
    .ctrl (rem_ctrl),
    .stat (rem_stat)
  );

  // Times 60 done as (x << 6) - (x << 2).
  assign sec_of_hour = (DIV_W'(now.minute) << 6) - (DIV_W'(now.minute) << 2)
                     + DIV_W'(now.second);
  assign min_of_day  = (DIV_W'(now.hour) << 6) - (DIV_W'(now.hour) << 2)
                     + DIV_W'(now.minute);

  // A period of zero behaves as a period of one.
  assign sec_divisor = (second_period == '0) ? DIV_W'(1) : DIV_W'(second_period);
  assign min_divisor = (minute_period == '0) ? DIV_W'(1) : DIV_W'(minute_period);

  always_ff @(posedge clk) begin
    if (rst) begin
      second_period <= SEC_PERIOD_RESET;
      minute_period <= MIN_PERIOD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SECOND_PERIOD: second_period <= cfg_data[SEC_PERIOD_W-1:0];
        REG_MINUTE_PERIOD: minute_period <= cfg_data[MIN_PERIOD_W-1:0];
        default: begin
          second_period <= second_period;
        end
      endcase
    end
  end

  // Sequencer: run the remainder unit for seconds, then minutes, then
  // hand the word to the output register.
  always_comb begin
    state_next        = state;
    rem_ctrl.start    = 1'b0;
    rem_ctrl.dividend = sec_of_hour;
    rem_ctrl.divisor  = sec_divisor;
    in_stall          = 1'b1;
    load_out          = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = S_SEC_START;
        end
      end
      S_SEC_START: begin
        rem_ctrl.start = 1'b1;
        state_next     = S_SEC_WAIT;
      end
      S_SEC_WAIT: begin
        if (!rem_stat.busy) begin
          state_next = S_MIN_START;
        end
      end
      S_MIN_START: begin
        rem_ctrl.start    = 1'b1;
        rem_ctrl.dividend = min_of_day;
        rem_ctrl.divisor  = min_divisor;
        state_next        = S_MIN_WAIT;
      end
      S_MIN_WAIT: begin
        if (!rem_stat.busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture each remainder result once the unit has finished.
  always_ff @(posedge clk) begin
    if (state == S_SEC_WAIT && !rem_stat.busy) begin
      sec_zero <= rem_stat.zero;
    end
    if (state == S_MIN_WAIT && !rem_stat.busy) begin
      min_zero <= rem_stat.zero;
    end
  end

  // A trigger fires on a zero residue while its flag is clear; the flag
  // then follows the residue, so it re-arms on the first nonzero residue.
  always_ff @(posedge clk) begin
    if (rst) begin
      second_done <= 1'b0;
      minute_done <= 1'b0;
    end else if (load_out) begin
      second_done <= sec_zero;
      minute_done <= min_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.hour        <= now.hour;
      out_data.minute      <= now.minute;
      out_data.second      <= now.second;
      out_data.second_fire <= sec_zero && !second_done;
      out_data.minute_fire <= min_zero && !minute_done;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> in_stall) else $error("new word taken while one is in flight");

  a_sec_fire_sets_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.second_fire) |-> second_done)
    else $error("seconds trigger fired without setting its flag");

  a_min_fire_sets_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.minute_fire) |-> minute_done)
    else $error("minutes trigger fired without setting its flag");

endmodule

>>> dv/time_of_day_clock_periodic_trigger_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-of-day clock testbench
// Sends tick and set words through the valid/stall input channel, predicts
// the time and both one-shot trigger flags for every accepted word, and
// compares each returned word with the oldest prediction. The run covers
// several period settings, random idling on both sides and one long receiver
// hold-off.
// ----------------------------------------------------------------------------
module time_of_day_clock_periodic_trigger_top_tb;
  import todc_pkg::*;

  localparam int HALF_PERIOD = 4;
  // The longest quiet stretch of a correct run is the receiver hold-off plus
  // one item's latency; the watchdog allows several times that.
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int ITEMS_PER_SETTING = 84;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_word_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_data;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  time_of_day_clock_periodic_trigger_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Words waiting to be driven, and predicted result words in arrival order.
  in_word_t  items_to_send[$];
  out_word_t time_words_due[$];

  // Idling controls, set per phase by the stimulus process.
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  logic hold_arm = 1'b0;

  int   bad_words = 0;
  int   quiet_cycles = 0;
  logic in_fire = 1'b0;

  // Predicted time of day, trigger flags and period registers.
  int   tod_tenths, tod_second, tod_minute, tod_hour;
  logic sec_fired, min_fired;
  int   sec_period_r, min_period_r;

  // A trigger fires when its residue is zero and it has not fired yet. The
  // done flag stays set while the residue is zero and clears otherwise.
  // A zero period behaves like a period of one. Returns {fire, done}.
  function automatic logic [1:0] trigger_step(input int count, input int period,
                                               input logic done);
    int p;
    p = (period == 0) ? 1 : period;
    if (count % p == 0) return {~done, 1'b1};
    return 2'b00;
  endfunction

  // Applies one input word to the predicted clock and returns the word the
  // block must report for it.
  function automatic out_word_t next_time_word(input in_word_t w);
    out_word_t  r;
    logic [1:0] s_shot, m_shot;
    case (w.operation)
      OP_TICK: begin
        tod_tenths++;
        if (tod_tenths >= TICKS_PER_SECOND) begin
          tod_tenths = 0;
          if (tod_second == int'(SECOND_LAST)) begin
            tod_second = 0;
            if (tod_minute == int'(MINUTE_LAST)) begin
              tod_minute = 0;
              tod_hour = (tod_hour == int'(HOUR_LAST)) ? 0 : tod_hour + 1;
            end else begin
              tod_minute++;
            end
          end else begin
            tod_second++;
          end
        end
      end
      // Out-of-range set values leave the time unchanged.
      OP_SET_HOUR:   if (w.value <= VALUE_W'(HOUR_LAST)) tod_hour = int'(w.value);
      OP_SET_MINUTE: if (w.value <= MINUTE_LAST) tod_minute = int'(w.value);
      OP_SET_SECOND: if (w.value <= SECOND_LAST) tod_second = int'(w.value);
      default: ;
    endcase
    s_shot = trigger_step(tod_second + 60 * tod_minute, sec_period_r, sec_fired);
    m_shot = trigger_step(tod_minute + 60 * tod_hour, min_period_r, min_fired);
    sec_fired = s_shot[0];
    min_fired = m_shot[0];
    r.hour        = HOUR_W'(tod_hour);
    r.minute      = MINUTE_W'(tod_minute);
    r.second      = SECOND_W'(tod_second);
    r.second_fire = s_shot[1];
    r.minute_fire = m_shot[1];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [11:0] want,
                             input logic [11:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      bad_words++;
    end
  endtask

  // Driver: a new word goes out at the falling edge once the previous one
  // was taken (or none was offered). A stalled word is held unchanged, and
  // valid only drops after an acceptance, never because of stall.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (items_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_data  <= items_to_send.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall per phase, plus one long hold-off counted here so
  // that the block fills up and pushes back on the sender.
  int   hold_left = 0;
  logic hold_used = 1'b0;
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_used) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Monitor: at each rising edge, predict for an accepted input word and
  // check an accepted output word against the oldest prediction. The
  // watchdog counts edges at which neither channel moves a word.
  always @(posedge clk) begin
    out_word_t want;
    logic      out_fire;
    if (rst) begin
      in_fire = 1'b0;
    end else begin
      in_fire  = in_valid && !in_stall;
      out_fire = out_valid && !out_stall;
      if (in_fire) time_words_due.push_back(next_time_word(in_data));
      if (out_fire) begin
        if (time_words_due.size() == 0) begin
          $error("result word with no item outstanding: %h", out_data);
          bad_words++;
        end else begin
          want = time_words_due.pop_front();
          check_field("hour", 12'(want.hour), 12'(out_data.hour));
          check_field("minute", 12'(want.minute), 12'(out_data.minute));
          check_field("second", 12'(want.second), 12'(out_data.second));
          check_field("second_fire", 12'(want.second_fire),
                      12'(out_data.second_fire));
          check_field("minute_fire", 12'(want.minute_fire),
                      12'(out_data.minute_fire));
        end
      end
      quiet_cycles = (in_fire || out_fire) ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $error("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic push_item(input op_t op, input int val);
    in_word_t w;
    w.operation = op;
    w.value     = VALUE_W'(val);
    items_to_send.push_back(w);
  endtask

  // Period registers are written at a falling edge only while the block is
  // idle, and the predictor takes the new value at the same moment.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_SECOND_PERIOD) sec_period_r = int'(data[SEC_PERIOD_W-1:0]);
    else if (idx == REG_MINUTE_PERIOD) min_period_r = int'(data[MIN_PERIOD_W-1:0]);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Every item returns exactly one word, so the block is idle once nothing
  // is queued, nothing is offered and no prediction is outstanding.
  task automatic wait_idle();
    while (items_to_send.size() != 0 || in_valid || time_words_due.size() != 0)
      @(posedge clk);
  endtask

  // Random traffic. Most of it jumps the clock close to a carry with a full
  // set sequence and then ticks through, so that minute, hour and midnight
  // wraps and the long-period triggers are reached. The rest is single
  // ticks with junk values and sets with any value, in range or not.
  task automatic queue_random_items(input int count);
    int added, pick, hr, mn, sc, ticks;
    added = 0;
    while (added < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        hr = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 23 : 0)
                                          : $urandom_range(0, 23);
        mn = ($urandom_range(0, 2) == 0) ? ($urandom_range(0, 1) ? 59 : 0)
                                          : $urandom_range(0, 59);
        sc = $urandom_range(0, 1) ? $urandom_range(55, 59) : $urandom_range(0, 59);
        ticks = $urandom_range(5, 25);
        push_item(OP_SET_HOUR, hr);
        push_item(OP_SET_MINUTE, mn);
        push_item(OP_SET_SECOND, sc);
        repeat (ticks) push_item(OP_TICK, $urandom_range(0, 63));
        added += 3 + ticks;
      end else if (pick < 85) begin
        push_item(OP_TICK, $urandom_range(0, 63));
        added++;
      end else begin
        push_item(op_t'($urandom_range(0, 3)), $urandom_range(0, 63));
        added++;
      end
    end
  endtask

  task automatic run_setting(input int sec_p, input int min_p);
    write_reg(REG_SECOND_PERIOD, CFG_DATA_W'(sec_p));
    write_reg(REG_MINUTE_PERIOD, CFG_DATA_W'(min_p));
    queue_random_items(ITEMS_PER_SETTING);
    wait_idle();
  endtask

  initial begin
    // Predicted state after reset, periods at their reset values.
    tod_tenths = 0;
    tod_second = 0;
    tod_minute = 0;
    tod_hour   = 0;
    sec_fired  = 1'b0;
    min_fired  = 1'b0;
    sec_period_r = int'(SEC_PERIOD_RESET);
    min_period_r = int'(MIN_PERIOD_RESET);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Sender idles a quarter of the time, receiver about half.
    send_idle_pct = 24;
    stall_pct     = 54;

    // Directed words with the reset periods. The first tick fires both
    // triggers at 00:00:00. Then 23:59:59 is set and ten ticks force the
    // midnight wrap (one of them carrying a junk value). Out-of-range sets
    // must leave the time alone, and the last sets hit a second-of-hour
    // multiple of the period.
    push_item(OP_TICK, 0);
    push_item(OP_SET_HOUR, 23);
    push_item(OP_SET_MINUTE, 59);
    push_item(OP_SET_SECOND, 59);
    push_item(OP_TICK, 63);
    repeat (9) push_item(OP_TICK, 0);
    push_item(OP_SET_HOUR, 24);
    push_item(OP_SET_HOUR, 63);
    push_item(OP_SET_MINUTE, 60);
    push_item(OP_SET_MINUTE, 63);
    push_item(OP_SET_SECOND, 60);
    push_item(OP_SET_SECOND, 63);
    push_item(OP_SET_MINUTE, 30);
    push_item(OP_SET_SECOND, 0);
    push_item(OP_SET_HOUR, 0);
    queue_random_items(ITEMS_PER_SETTING);
    wait_idle();

    // Smallest seconds period against a whole-day minutes period.
    run_setting(1, 1440);

    // Idling the other way round: zero and whole-hour periods, then a minutes
    // period beyond the minute-of-day range, which only fires at a zero count.
    send_idle_pct = 54;
    stall_pct     = 24;
    run_setting(3600, 0);
    run_setting(0, 2047);

    // No random idling; the receiver takes one long hold-off instead.
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_arm      = 1'b1;
    run_setting(4095, $urandom_range(2, 90));
    run_setting($urandom_range(2, 120), $urandom_range(2, 1440));

    // Let any stray word show up before the verdict.
    repeat (64) @(posedge clk);
    if (bad_words == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
